// ----- hw/rtl/bpq_pkg.sv -----
// shared types, constants and codes of the bucket priority queue
package bpq_pkg;

  // default configuration
  localparam int NUM_KEYS_DEF   = 1024;
  localparam int POOL_DEPTH_DEF = 4096;
  localparam int VALUE_BITS_DEF = 16;

  // bitmap is searched one word of this many buckets per cycle
  localparam int SCAN_W   = 32;
  localparam int SCAN_LOG = 5;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_SCAN,
    S_POP_HEAD,
    S_POP_ENTRY,
    S_POP_WR,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    push_rd;
    logic    push_wr;
    logic    scan_step;
    logic    pop_head;
    logic    pop_entry;
    logic    pop_wr;
    logic    set_st;
    status_t st;
    logic    out_load;
  } bpq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_pop;
    logic key_bad;
    logic pool_full;
    logic no_items;
    logic scan_hit;
    logic out_busy;
  } bpq_stat_t;

endpackage

// ----- hw/rtl/bucket_priority_queue.sv -----
// Bucket priority queue: a push stores a value in the LIFO bucket of its key,
// a pop returns the newest value of the lowest non-empty bucket and its key.
// Every request gives exactly one response with status, item count and empty
// flag. A push passes from decode through a head and link read state and a
// write state to the finish state, which waits until the output register is
// free and loads the response; the next request is taken in idle after that.
// A pop passes from decode to a search of the occupancy bitmap, one 32-bucket
// word at a time starting at the word of the lowest-key pointer, then reads
// the bucket head, reads the entry, writes back and finishes. A rejected
// request (bad key, full pool, empty pop) goes from decode straight to finish.
// The order follows the dependent single-port reads of the bucket head memory
// and the entry pool. One request is in work at a time; the next is taken
// while the previous response waits in the output register. No clearing pass runs after reset.
module bucket_priority_queue import bpq_pkg::*; #(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [$clog2(NUM_KEYS):0]       key,
  input  logic [VALUE_BITS-1:0]           push_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [VALUE_BITS-1:0]           pop_value,
  output logic [$clog2(NUM_KEYS)-1:0]     pop_key,
  output logic [1:0]                      status,
  output logic [$clog2(POOL_DEPTH+1)-1:0] item_count,
  output logic                            is_empty
);

  bpq_cmd_t  cmd;
  bpq_stat_t stat;

  // sequencing
  bpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  bpq_datapath #(
    .NUM_KEYS   (NUM_KEYS),
    .POOL_DEPTH (POOL_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .key        (key),
    .push_value (push_value),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .pop_value  (pop_value),
    .pop_key    (pop_key),
    .status     (status),
    .item_count (item_count),
    .is_empty   (is_empty)
  );

endmodule

// ----- hw/rtl/bpq_ctrl.sv -----
// controller state machine of the bucket priority queue
module bpq_ctrl import bpq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bpq_stat_t stat,
  output bpq_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.is_pop) begin
          if (stat.key_bad || stat.pool_full) state_next = S_FINISH;
          else state_next = S_PUSH_RD;
        end else begin
          if (stat.no_items) state_next = S_FINISH;
          else state_next = S_SCAN;
        end
      end
      S_PUSH_RD:   state_next = S_PUSH_WR;
      S_PUSH_WR:   state_next = S_FINISH;
      S_SCAN: begin
        if (stat.scan_hit) state_next = S_POP_HEAD;
      end
      S_POP_HEAD:  state_next = S_POP_ENTRY;
      S_POP_ENTRY: state_next = S_POP_WR;
      S_POP_WR:    state_next = S_FINISH;
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.st   = ST_OK;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        if (!stat.is_pop) begin
          if (stat.key_bad) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_RANGE;
          end else if (stat.pool_full) begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_FULL;
          end
        end else if (stat.no_items) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_EMPTY;
        end
      end
      S_PUSH_RD:   cmd.push_rd = 1'b1;
      S_PUSH_WR: begin
        cmd.push_wr = 1'b1;
        cmd.set_st  = 1'b1;
      end
      S_SCAN:      cmd.scan_step = 1'b1;
      S_POP_HEAD:  cmd.pop_head = 1'b1;
      S_POP_ENTRY: cmd.pop_entry = 1'b1;
      S_POP_WR: begin
        cmd.pop_wr = 1'b1;
        cmd.set_st = 1'b1;
      end
      S_FINISH:    cmd.out_load = !stat.out_busy;
      default:     cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/bpq_datapath.sv -----
// bitmap, bucket heads, entry pool, counters and output register
module bpq_datapath import bpq_pkg::*; #(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpq_cmd_t                            cmd,
  output bpq_stat_t                           stat,
  input  logic                                mode,
  input  logic [$clog2(NUM_KEYS):0]           key,
  input  logic [VALUE_BITS-1:0]               push_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [VALUE_BITS-1:0]               pop_value,
  output logic [$clog2(NUM_KEYS)-1:0]         pop_key,
  output logic [1:0]                          status,
  output logic [$clog2(POOL_DEPTH+1)-1:0]     item_count,
  output logic                                is_empty
);

  localparam int KIDX_W = $clog2(NUM_KEYS);
  localparam int KEY_W  = KIDX_W + 1;
  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
  localparam int WORDS  = (NUM_KEYS + SCAN_W - 1) / SCAN_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int KF_W   = WIDX_W + SCAN_LOG;
  localparam int MAP_W  = WORDS * SCAN_W;

  localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(POOL_DEPTH);
  localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(NUM_KEYS);

  // lowest set bit of one bitmap word
  function automatic logic [SCAN_LOG-1:0] first_set(input logic [SCAN_W-1:0] w);
    logic [SCAN_LOG-1:0] pos;
    pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (w[i]) pos = SCAN_LOG'(i);
    end
    return pos;
  endfunction

  // captured request
  logic                  mode_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;

  // queue state
  logic [MAP_W-1:0]  bitmap;
  logic [PTR_W-1:0]  free_head;
  logic [PTR_W-1:0]  high_water;
  logic [PTR_W-1:0]  count;
  logic [KEY_W-1:0]  lowest;

  // working registers
  logic [WIDX_W-1:0]     scan_w;
  logic [KIDX_W-1:0]     k_r;
  logic [PTR_W-1:0]      head_rd;
  logic [PTR_W-1:0]      next_rd;
  logic [VALUE_BITS-1:0] data_rd;
  logic [VALUE_BITS-1:0] res_value;
  logic [KIDX_W-1:0]     res_key;
  status_t               res_st;

  // memories
  logic [PTR_W-1:0]      head_mem [NUM_KEYS];
  logic [PTR_W-1:0]      next_mem [POOL_DEPTH];
  logic [VALUE_BITS-1:0] data_mem [POOL_DEPTH];

  logic [KIDX_W-1:0] key_idx;
  logic              use_free;
  logic [PTR_W-1:0]  alloc;
  logic [SCAN_W-1:0] scan_word;
  logic [KF_W-1:0]   k_full;
  logic [KF_W-1:0]   start_full;

  assign key_idx    = key_r[KIDX_W-1:0];
  assign use_free   = (free_head != NULL_PTR);
  assign alloc      = use_free ? free_head : high_water;
  assign scan_word  = bitmap[scan_w*SCAN_W +: SCAN_W];
  assign k_full     = {scan_w, first_set(scan_word)};
  assign start_full = KF_W'(lowest[KIDX_W-1:0]) >> SCAN_LOG;

  // status to the controller
  always_comb begin
    stat.is_pop    = mode_r;
    stat.key_bad   = (key_r >= KEY_LIMIT);
    stat.pool_full = !use_free && (high_water == NULL_PTR);
    stat.no_items  = (count == '0);
    stat.scan_hit  = |scan_word;
    stat.out_busy  = out_valid && !out_ready;
  end

  // request capture, scan and result staging
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode;
      key_r     <= key;
      val_r     <= push_value;
      res_value <= '0;
      res_key   <= '0;
      scan_w    <= start_full[WIDX_W-1:0];
    end
    if (cmd.scan_step) begin
      if (|scan_word) k_r <= k_full[KIDX_W-1:0];
      else scan_w <= scan_w + 1'b1;
    end
    if (cmd.set_st) res_st <= cmd.st;
    if (cmd.pop_wr) begin
      res_value <= data_rd;
      res_key   <= k_r;
    end
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (cmd.push_wr) head_mem[key_idx] <= alloc;
    else if (cmd.pop_wr) head_mem[k_r] <= next_rd;
    if (cmd.push_rd) head_rd <= head_mem[key_idx];
    else if (cmd.pop_head) head_rd <= head_mem[k_r];
  end

  // entry link memory
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      next_mem[alloc[IDX_W-1:0]] <= bitmap[key_idx] ? head_rd : NULL_PTR;
    end else if (cmd.pop_wr) begin
      next_mem[head_rd[IDX_W-1:0]] <= free_head;
    end
    if (cmd.push_rd) next_rd <= next_mem[free_head[IDX_W-1:0]];
    else if (cmd.pop_entry) next_rd <= next_mem[head_rd[IDX_W-1:0]];
  end

  // entry payload memory
  always_ff @(posedge clk) begin
    if (cmd.push_wr) data_mem[alloc[IDX_W-1:0]] <= val_r;
    if (cmd.pop_entry) data_rd <= data_mem[head_rd[IDX_W-1:0]];
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap     <= '0;
      free_head  <= NULL_PTR;
      high_water <= '0;
      count      <= '0;
      lowest     <= KEY_LIMIT;
    end else if (cmd.push_wr) begin
      bitmap[key_idx] <= 1'b1;
      count           <= count + 1'b1;
      if (key_r < lowest) lowest <= key_r;
      if (use_free) free_head <= next_rd;
      else high_water <= high_water + 1'b1;
    end else if (cmd.pop_wr) begin
      if (next_rd == NULL_PTR) bitmap[k_r] <= 1'b0;
      free_head <= head_rd;
      count     <= count - 1'b1;
      lowest    <= KEY_W'(k_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pop_value  <= res_value;
      pop_key    <= res_key;
      status     <= res_st;
      item_count <= count;
      is_empty   <= (count == '0);
    end
  end

endmodule

// ----- hw/rtl/bpq_checker.sv -----
// port-level checks of the bucket priority queue and their binding
module bpq_checker import bpq_pkg::*; #(
  parameter int NUM_KEYS   = NUM_KEYS_DEF,
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [VALUE_BITS-1:0]           pop_value,
  input logic [$clog2(NUM_KEYS)-1:0]     pop_key,
  input logic [1:0]                      status,
  input logic [$clog2(POOL_DEPTH+1)-1:0] item_count,
  input logic                            is_empty
);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status))
    else $error("response changed while stalled");

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (item_count == '0)))
    else $error("empty flag disagrees with item count");

  // failed request returns no payload
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (pop_value == '0) && (pop_key == '0))
    else $error("failed request returned payload");

  // pop of an empty queue leaves it empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> is_empty)
    else $error("empty pop reported stored items");

endmodule

bind bucket_priority_queue bpq_checker #(
  .NUM_KEYS   (NUM_KEYS),
  .POOL_DEPTH (POOL_DEPTH),
  .VALUE_BITS (VALUE_BITS)
) u_bpq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pop_value  (pop_value),
  .pop_key    (pop_key),
  .status     (status),
  .item_count (item_count),
  .is_empty   (is_empty)
);

// ----- test/tb_bucket_priority_queue.sv -----
// self-checking testbench of the bucket priority queue
module tb_bucket_priority_queue;
  import bpq_pkg::*;

  localparam int KEYS      = 1024;
  localparam int DEPTH     = 4096;
  localparam int FILL      = 100;
  localparam logic [12:0] NO_ENTRY = 13'(DEPTH);
  localparam int STALL_MAX = 5000;
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct {
    logic        mode;
    logic [10:0] key;
    logic [15:0] value;
    int          phase;
    bit          drain;
  } request_t;

  typedef struct {
    logic [15:0] value;
    logic [9:0]  key;
    status_t     st;
    logic [12:0] count;
    logic        empty;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_PUSH;
  logic [10:0] key = '0;
  logic [15:0] push_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] pop_value;
  logic [9:0]  pop_key;
  logic [1:0]  status;
  logic [12:0] item_count;
  logic        is_empty;

  bucket_priority_queue u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .key(key), .push_value(push_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .pop_value(pop_value), .pop_key(pop_key), .status(status),
    .item_count(item_count), .is_empty(is_empty)
  );

  // idle percentages per phase: none, sender, receiver, both
  int send_idle [4] = '{0, 60, 0, 12};
  int recv_stall[4] = '{0, 0, 60, 12};

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       cur_phase = 0;
  logic     req_taken = 1'b0;
  int       mismatches = 0;
  int       stall_cycles = 0;
  int       answers_seen = 0;
  int       status_seen[4] = '{0, 0, 0, 0};

  // shadow copy of the queue contents
  logic [12:0] q_head[KEYS];
  bit          q_nonempty[KEYS];
  logic [12:0] q_next[DEPTH];
  logic [15:0] q_data[DEPTH];
  logic [12:0] q_free;
  logic [12:0] q_high;
  logic [12:0] q_stored;
  logic [10:0] q_lowest;

  function automatic void queue_clear();
    for (int i = 0; i < KEYS; i++) begin
      q_head[i] = NO_ENTRY;
      q_nonempty[i] = 1'b0;
    end
    q_free = NO_ENTRY;
    q_high = '0;
    q_stored = '0;
    q_lowest = 11'(KEYS);
  endfunction

  function automatic answer_t queue_apply(request_t r);
    answer_t a;
    int k;
    logic [12:0] idx;
    a.value = '0;
    a.key = '0;
    a.st = ST_OK;
    if (r.mode == MODE_PUSH) begin
      // push onto the bucket stack, taking the free list first
      if (r.key >= KEYS) a.st = ST_RANGE;
      else if (q_free == NO_ENTRY && q_high == DEPTH) a.st = ST_FULL;
      else begin
        if (q_free != NO_ENTRY) begin
          idx = q_free;
          q_free = q_next[idx];
        end else begin
          idx = q_high;
          q_high++;
        end
        q_data[idx] = r.value;
        q_next[idx] = q_head[r.key];
        q_head[r.key] = idx;
        q_nonempty[r.key] = 1'b1;
        q_stored++;
        if (r.key < q_lowest) q_lowest = r.key;
      end
    end else if (q_stored == 0) begin
      a.st = ST_EMPTY;
    end else begin
      // search upward from the lowest pointer
      k = int'(q_lowest);
      while (k < KEYS && !q_nonempty[k]) k++;
      if (k >= KEYS || q_head[k] == NO_ENTRY) begin
        if (k < KEYS) q_nonempty[k] = 1'b0;
        a.st = ST_EMPTY;
      end else begin
        idx = q_head[k];
        a.value = q_data[idx];
        a.key = k[9:0];
        q_head[k] = q_next[idx];
        if (q_head[k] == NO_ENTRY) q_nonempty[k] = 1'b0;
        q_next[idx] = q_free;
        q_free = idx;
        q_stored--;
        q_lowest = k[10:0];
      end
    end
    a.count = q_stored;
    a.empty = (q_stored == 0);
    return a;
  endfunction

  task automatic add_req(logic m, int k, int v, int ph, bit drain = 0);
    request_t r;
    r.mode = m;
    r.key = k[10:0];
    r.value = v[15:0];
    r.phase = ph;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || req_taken) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].drain && expected_answers.size() != 0) &&
            $urandom_range(0, 99) >= send_idle[pending_reqs[0].phase]) begin
          mode <= pending_reqs[0].mode;
          key <= pending_reqs[0].key;
          push_value <= pending_reqs[0].value;
          cur_phase <= pending_reqs[0].phase;
          in_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall[cur_phase]);
    end
  end

  // monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    request_t r;
    answer_t  e;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        r.mode = mode;
        r.key = key;
        r.value = push_value;
        expected_answers.push_back(queue_apply(r));
      end
      if (out_valid && out_ready) begin
        answers_seen++;
        status_seen[status]++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response status=%0d", status);
        end else begin
          e = expected_answers.pop_front();
          if (pop_value !== e.value || pop_key !== e.key || status !== e.st ||
              item_count !== e.count || is_empty !== e.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp val=%h key=%0d st=%0d cnt=%0d emp=%0b",
                       e.value, e.key, e.st, e.count, e.empty,
                       " got val=%h key=%0d st=%0d cnt=%0d emp=%0b",
                       pop_value, pop_key, status, item_count, is_empty);
          end
        end
      end
      // watchdog
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("tb_bucket_priority_queue: errors");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    queue_clear();
    // directed: extremes, range errors, lifo order, pointer behavior
    add_req(MODE_POP, 0, 0, 0);
    add_req(MODE_PUSH, 0, 16'h0000, 0);
    add_req(MODE_PUSH, 1023, 16'hffff, 0);
    add_req(MODE_PUSH, 1024, 16'h1234, 0);
    add_req(MODE_PUSH, 2047, 16'hffff, 0);
    add_req(MODE_PUSH, 7, 16'haaaa, 0);
    add_req(MODE_PUSH, 7, 16'h5555, 0);
    for (int i = 0; i < 4; i++) add_req(MODE_POP, 2047, 16'hffff, 0);
    add_req(MODE_POP, 0, 0, 0);
    add_req(MODE_PUSH, 500, 16'h0f0f, 0, 1);
    add_req(MODE_POP, 0, 0, 0);
    add_req(MODE_PUSH, 600, 16'hf0f0, 0);
    add_req(MODE_POP, 0, 0, 0);
    add_req(MODE_PUSH, 3, 16'h8001, 0);
    add_req(MODE_POP, 0, 0, 0);
    add_req(MODE_POP, 0, 0, 0);
    // load a batch of entries, then drain it back through the free list
    for (int i = 0; i < FILL; i++)
      add_req(MODE_PUSH, $urandom_range(0, 63), $urandom, 0, i == 0);
    add_req(MODE_PUSH, 5, 16'hbeef, 0);
    add_req(MODE_PUSH, 1500, 16'hbeef, 0);
    for (int i = 0; i <= FILL + 1; i++) add_req(MODE_POP, 0, 0, 0);
    // random traffic in four idle phases
    for (int ph = 1; ph <= 4; ph++) begin
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(0, 99) < 55)
          add_req(MODE_PUSH, ($urandom_range(0, 9) == 0) ? $urandom_range(1024, 2047)
                  : $urandom_range(0, 1023), $urandom, ph % 4, i == 75);
        else
          add_req(MODE_POP, $urandom_range(0, 2047), $urandom, ph % 4);
      end
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_reqs.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d responses: %0d ok, %0d empty pops, %0d bad keys, %0d pool full",
             answers_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("batch load and drain past empty, random traffic under four idle patterns");
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("tb_bucket_priority_queue: clean");
    end else begin
      $display("tb_bucket_priority_queue: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_ctrl.sv
hw/rtl/bpq_datapath.sv
hw/rtl/bucket_priority_queue.sv
hw/rtl/bpq_checker.sv
test/tb_bucket_priority_queue.sv
